// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Shared field types, opcodes and status codes.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int OP_W  = 3;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;
  localparam int ST_W  = 3;

  typedef logic [OP_W-1:0]  opcode_t;
  typedef logic [IDX_W-1:0] blk_idx_t;
  typedef logic [CNT_W-1:0] blk_cnt_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam opcode_t OP_CHECK_READ    = 3'd0;
  localparam opcode_t OP_ALLOC         = 3'd1;
  localparam opcode_t OP_FREE          = 3'd2;
  localparam opcode_t OP_CHECK_REWRITE = 3'd3;
  localparam opcode_t OP_FIND_FREE     = 3'd4;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_RANGE      = 3'd1;
  localparam status_t ST_BLOCK_FREE = 3'd2;
  localparam status_t ST_FULL       = 3'd3;
  localparam status_t ST_BUSY       = 3'd4;
  localparam status_t ST_NONE       = 3'd5;

endpackage

// ===== sv/bba_if.sv =====
// ----------------------------------------------------------------------------
// Block bitmap allocator channel interfaces
// Request, result and block count configuration channels.
// ----------------------------------------------------------------------------
interface bba_in_if import bba_pkg::*; ();
  logic     valid;
  logic     ready;
  opcode_t  opcode;
  blk_idx_t block_index;

  modport source (output valid, output opcode, output block_index, input ready);
  modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic     valid;
  logic     ready;
  status_t  status;
  blk_idx_t found_index;
  logic     found;
  blk_cnt_t free_count;
  blk_idx_t first_free;
  logic     first_free_valid;

  modport source (output valid, output status, output found_index, output found,
                  output free_count, output first_free, output first_free_valid,
                  input ready);
  modport sink   (input valid, input status, input found_index, input found,
                  input free_count, input first_free, input first_free_valid,
                  output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic     valid;
  logic     ready;
  blk_cnt_t block_count;

  modport source (output valid, output block_count, input ready);
  modport sink   (input valid, input block_count, output ready);
endinterface

// ===== sv/block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Block bitmap allocator
// Used/free bitmap over disk blocks with a free count and a first-free hint.
// ----------------------------------------------------------------------------
// The bitmap sits in one synchronous RAM of WORD_BITS-wide words. A check
// reads one word, and an allocate or free is a read-modify-write of one
// word. Such a request passes the read state and then the done state, where
// its result is registered, and the next request is accepted only once the
// block is back in idle, so requests never overlap. A search (find free, or
// allocating the hinted block while other blocks stay free) adds a prepare
// state plus one scan step per bitmap word scanned. A result that waits for
// the receiver holds the following request at its final step.
// After reset and after every block count write the RAM is cleared one word
// per cycle; no request is accepted during that time. A block count write
// is accepted only while no request is in progress. WORD_BITS must be a
// power of two.
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic clk,
  input  logic rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  bba_cfg_if.sink   cfg_ch
);

  localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WL         = $clog2(WORD_BITS);
  localparam int RST_BLOCKS = (MAX_BLOCKS < 4096) ? MAX_BLOCKS : 4096;
  localparam logic [16:0]      MAX_L   = 17'(MAX_BLOCKS);
  localparam blk_cnt_t         RST_N   = CNT_W'(RST_BLOCKS);
  localparam logic [WL-1:0]    TOP_BIT = WL'(WORD_BITS - 1);
  localparam logic [AW-1:0]    LAST_CLR = AW'(NUM_WORDS - 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_PRE, S_SRCH, S_DONE} state_t;

  state_t   state_r;
  opcode_t  op_r;
  blk_idx_t idx_r;
  blk_idx_t start_r;
  blk_cnt_t n_r;
  blk_cnt_t fc_r;
  blk_cnt_t ff_r;
  logic     ffk_r;
  status_t  status_r;
  blk_cnt_t fidx_r;
  logic     fnd_r;
  logic     srch_alloc_r;
  logic [AW-1:0] w_r;
  logic     clearing_r;
  logic [AW-1:0] clr_r;

  logic     out_valid_r;
  status_t  out_status_r;
  blk_idx_t out_fidx_r;
  logic     out_fnd_r;
  blk_cnt_t out_fc_r;
  blk_idx_t out_ff_r;
  logic     out_ffv_r;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] rd_data;

  blk_cnt_t in_w13, idx_w13, start_w13, last_blk, last_w13, n_clamp, hit_blk;
  logic [AW-1:0]        in_addr, idx_addr, start_addr, last_addr;
  logic [WL-1:0]        bit_sel, start_bit, last_bit, scan_pos;
  logic [WORD_BITS-1:0] bit_mask, lo_mask, hi_mask, cand;
  logic                 cur_bit, in_range, scan_hit;

  assign in_w13    = {1'b0, in_ch.block_index} >> WL;
  assign idx_w13   = {1'b0, idx_r} >> WL;
  assign start_w13 = {1'b0, start_r} >> WL;
  assign last_blk  = n_r - 1'b1;
  assign last_w13  = last_blk >> WL;
  assign in_addr    = in_w13[AW-1:0];
  assign idx_addr   = idx_w13[AW-1:0];
  assign start_addr = start_w13[AW-1:0];
  assign last_addr  = last_w13[AW-1:0];
  assign bit_sel    = idx_r[WL-1:0];
  assign start_bit  = start_r[WL-1:0];
  assign last_bit   = last_blk[WL-1:0];

  assign bit_mask = WORD_BITS'(1) << bit_sel;
  assign cur_bit  = rd_data[bit_sel];
  assign in_range = {1'b0, idx_r} < n_r;

  assign lo_mask = (w_r == start_addr) ? ({WORD_BITS{1'b1}} << start_bit)
                                       : {WORD_BITS{1'b1}};
  assign hi_mask = (w_r == last_addr) ? ({WORD_BITS{1'b1}} >> (TOP_BIT - last_bit))
                                      : {WORD_BITS{1'b1}};
  assign cand    = ~rd_data & lo_mask & hi_mask;
  assign hit_blk = (CNT_W'(w_r) << WL) | CNT_W'(scan_pos);

  assign n_clamp = ({4'b0, cfg_ch.block_count} > MAX_L) ? MAX_L[CNT_W-1:0]
                                                        : cfg_ch.block_count;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = rd_data;
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == S_RD && in_range) begin
      if (op_r == OP_ALLOC && fc_r != '0 && !cur_bit) begin
        mem_we    = 1'b1;
        mem_wdata = rd_data | bit_mask;
      end else if (op_r == OP_FREE && cur_bit) begin
        mem_we    = 1'b1;
        mem_wdata = rd_data & ~bit_mask;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  mem_raddr = in_addr;
      S_PRE:   mem_raddr = start_addr;
      default: mem_raddr = w_r + 1'b1;
    endcase
  end

  bba_bitmap_mem #(
    .WORDS (NUM_WORDS),
    .DW    (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  bba_free_scan #(
    .WB (WORD_BITS),
    .WL (WL)
  ) u_scan (
    .cand (cand),
    .hit  (scan_hit),
    .pos  (scan_pos)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !clearing_r && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.found_index      = out_fidx_r;
  assign out_ch.found            = out_fnd_r;
  assign out_ch.free_count       = out_fc_r;
  assign out_ch.first_free       = out_ff_r;
  assign out_ch.first_free_valid = out_ffv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= RST_N;
      fc_r         <= RST_N;
      ff_r         <= '0;
      ffk_r        <= 1'b1;
      clearing_r   <= 1'b1;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      srch_alloc_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        n_r        <= n_clamp;
        fc_r       <= n_clamp;
        ff_r       <= '0;
        ffk_r      <= (n_clamp != '0);
        clearing_r <= 1'b1;
        clr_r      <= '0;
      end else if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == LAST_CLR) begin
          clearing_r <= 1'b0;
        end
      end

      if (out_ch.valid && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            op_r     <= in_ch.opcode;
            idx_r    <= in_ch.block_index;
            status_r <= ST_OK;
            fidx_r   <= '0;
            fnd_r    <= 1'b0;
            state_r  <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_DONE;
          if (op_r == OP_CHECK_READ || op_r == OP_CHECK_REWRITE) begin
            if (!in_range) begin
              status_r <= ST_RANGE;
            end else if (!cur_bit) begin
              status_r <= ST_BLOCK_FREE;
            end
          end else if (op_r == OP_ALLOC) begin
            if (!in_range) begin
              status_r <= ST_RANGE;
            end else if (fc_r == '0) begin
              status_r <= ST_FULL;
            end else if (cur_bit) begin
              status_r <= ST_BUSY;
            end else begin
              fc_r <= fc_r - 1'b1;
              if (ffk_r && {1'b0, idx_r} == ff_r) begin
                if (fc_r != CNT_W'(1)) begin
                  start_r      <= idx_r;
                  srch_alloc_r <= 1'b1;
                  state_r      <= S_PRE;
                end else begin
                  ff_r  <= '0;
                  ffk_r <= 1'b0;
                end
              end
            end
          end else if (op_r == OP_FREE) begin
            if (!in_range) begin
              status_r <= ST_RANGE;
            end else if (cur_bit) begin
              fc_r <= fc_r + 1'b1;
              if (!ffk_r || {1'b0, idx_r} < ff_r) begin
                ff_r  <= {1'b0, idx_r};
                ffk_r <= 1'b1;
              end
            end
          end else if (op_r == OP_FIND_FREE) begin
            if (fc_r == '0) begin
              status_r <= ST_FULL;
            end else if ({1'b0, idx_r} > n_r) begin
              status_r <= ST_RANGE;
            end else if ({1'b0, idx_r} == n_r) begin
              status_r <= ST_NONE;
            end else begin
              start_r      <= idx_r;
              srch_alloc_r <= 1'b0;
              state_r      <= S_PRE;
            end
          end else begin
            status_r <= ST_RANGE;
          end
        end
        S_PRE: begin
          w_r     <= start_addr;
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          if (scan_hit) begin
            if (srch_alloc_r) begin
              ff_r <= hit_blk;
            end else begin
              fidx_r <= hit_blk;
              fnd_r  <= 1'b1;
            end
            state_r <= S_DONE;
          end else if (w_r == last_addr) begin
            if (srch_alloc_r) begin
              ff_r  <= '0;
              ffk_r <= 1'b0;
            end else begin
              status_r <= ST_NONE;
            end
            state_r <= S_DONE;
          end else begin
            w_r <= w_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_fidx_r   <= fidx_r[IDX_W-1:0];
            out_fnd_r    <= fnd_r;
            out_fc_r     <= fc_r;
            out_ff_r     <= ffk_r ? ff_r[IDX_W-1:0] : '0;
            out_ffv_r    <= ffk_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bba_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// Bitmap memory
// Simple dual-port synchronous RAM with one write and one registered read.
// ----------------------------------------------------------------------------
module bba_bitmap_mem #(
  parameter int WORDS = 128,
  parameter int DW    = 32,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bba_free_scan.sv =====
// ----------------------------------------------------------------------------
// Free bit scanner
// Finds the lowest set bit of a candidate word of free blocks.
// ----------------------------------------------------------------------------
module bba_free_scan #(
  parameter int WB = 32,
  parameter int WL = 5
) (
  input  logic [WB-1:0] cand,
  output logic          hit,
  output logic [WL-1:0] pos
);

  always_comb begin
    pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = WL'(i);
      end
    end
  end

  assign hit = |cand;

endmodule

// ===== sv/bba_checker.sv =====
// ----------------------------------------------------------------------------
// Block bitmap allocator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input status_t  status,
  input blk_idx_t found_index,
  input logic     found,
  input blk_cnt_t free_count,
  input blk_idx_t first_free,
  input logic     first_free_valid
);

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> status == ST_OK)
    else $error("A found block must come with an ok status.");

  a_no_found_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> found_index == '0)
    else $error("The found index must be zero when nothing was found.");

  a_hint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !first_free_valid |-> first_free == '0)
    else $error("An unknown hint must read as zero.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
      && $stable(found_index) && $stable(free_count) && $stable(first_free))
    else $error("A stalled result transaction changed.");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .found_index      (out_ch.found_index),
  .found            (out_ch.found),
  .free_count       (out_ch.free_count),
  .first_free       (out_ch.first_free),
  .first_free_valid (out_ch.first_free_valid)
);
